// ----- hw/rtl/falling_sand_grid_step_top_assert.svh -----
// Assertion macros for the falling sand grid block.
// Used by the top level only; no other dependencies.
`ifndef FALLING_SAND_GRID_STEP_TOP_ASSERT_SVH
`define FALLING_SAND_GRID_STEP_TOP_ASSERT_SVH
`define FSG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hw/rtl/fsg_pkg.sv -----
// Package for the falling sand grid block: types, constants and helpers.
// No dependencies.
package fsg_pkg;
   localparam int GridWidth  = 128;
   localparam int GridHeight = 64;
   localparam int MaxRadius  = 5;
   localparam int XW = $clog2(GridWidth);
   localparam int YW = $clog2(GridHeight);
   localparam int AW = XW + YW;
   localparam int CellCount = GridWidth * GridHeight;
   localparam int RW = $clog2(MaxRadius + 1) + 1;

   localparam logic [1:0] OP_PAINT = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_SAND  = 2'd1;
   localparam logic [1:0] KIND_STONE = 2'd2;
   localparam logic [1:0] MODE_ERASE = 2'd0;

   typedef struct packed {
      logic [1:0] opcode;
      logic [6:0] pos_x;
      logic [5:0] pos_y;
      logic [2:0] brush_radius;
      logic [1:0] brush_mode;
   } req_type;

   typedef struct packed {
      logic [1:0] cell_kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   function automatic logic [15:0] lfsr_next(input logic [15:0] s);
      return {s[14:0], s[15] ^ s[13] ^ s[12] ^ s[10]};
   endfunction
endpackage

// ----- hw/rtl/fsg_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fsg_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/falling_sand_grid_step_top.sv -----
// Top level of the falling sand grid: sequencer around one cell memory.
// Depends on fsg_pkg, fsg_ram and falling_sand_grid_step_top_assert.svh.
//
//   channel | ports                  | direction
//   req     | req_valid/stall/data   | in
//   rsp     | rsp_valid/stall/data   | out
//   csr     | csr_wr_en/csr_wr_data  | in
//
// After reset a clearing pass writes all 8192 cells, one per cycle, with req stalled.
// Paint visits each position of its (2r+1)^2 square; S_RWAIT is added where a cell is read.
// A tick visits each cell of 63 rows of 128; sand that moves diagonally adds S_TD2/S_TD3.
// A read passes S_RRD, S_RWAIT (skipped off the grid) and S_OUT, which registers the result.
// A stalled result holds only the output register; the next request waits in the output state.
module falling_sand_grid_step_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fsg_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fsg_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_PRD   = 4'd2;
   localparam logic [3:0] S_PCHK  = 4'd3;
   localparam logic [3:0] S_TRD   = 4'd4;
   localparam logic [3:0] S_TBEL  = 4'd5;
   localparam logic [3:0] S_TD1   = 4'd6;
   localparam logic [3:0] S_TD2   = 4'd7;
   localparam logic [3:0] S_RRD   = 4'd8;
   localparam logic [3:0] S_RWAIT = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;
   localparam logic [3:0] S_PNXT  = 4'd11;
   localparam logic [3:0] S_TNXT  = 4'd12;
   localparam logic [3:0] S_TD3   = 4'd13;
   localparam logic [3:0] S_TCLR  = 4'd14;

   localparam int XW = fsg_pkg::XW;
   localparam int YW = fsg_pkg::YW;
   localparam int AW = fsg_pkg::AW;
   localparam int RW = fsg_pkg::RW;
   localparam int DW = 2 * RW + 4;

   logic [3:0]  state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;
   logic [15:0] lfsr_ff, lfsr_in;
   fsg_pkg::req_type req_ff, req_in;
   fsg_pkg::rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [RW-1:0] i_ff, i_in, j_ff, j_in;
   logic [RW-1:0] rad_ff, rad_in;
   logic [XW-1:0] tx_ff, tx_in;
   logic [YW-1:0] ty_ff, ty_in;
   logic [7:0]  cur_ff, cur_in;
   logic        dir_ff, dir_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   fsg_ram #(.Width(8), .Depth(fsg_pkg::CellCount)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [15:0] lfsr_adv;
   logic [23:0] var_prod;
   logic signed [XW+RW:0] px;
   logic signed [YW+RW:0] py;
   logic in_disk, on_grid;
   logic signed [DW-1:0] i_ext, j_ext, r_ext, dsq, rsq;
   logic dsel;
   logic signed [XW+1:0] xa, xb;
   logic xa_ok, xb_ok;
   logic [YW-1:0] ty_dn;
   logic [5:0] var_sat;

   assign lfsr_adv = fsg_pkg::lfsr_next(lfsr_ff);
   assign var_prod = 24'(lfsr_adv) * 24'd51;
   assign px  = (XW+RW+1)'(req_ff.pos_x) + (XW+RW+1)'(i_ff);
   assign py  = (YW+RW+1)'(req_ff.pos_y) + (YW+RW+1)'(j_ff);
   assign i_ext = DW'(i_ff);
   assign j_ext = DW'(j_ff);
   assign r_ext = DW'(signed'({1'b0, rad_ff}));
   assign dsq = DW'(5) * (i_ext * i_ext + j_ext * j_ext);
   assign rsq = DW'(4) * r_ext * r_ext;
   assign in_disk = dsq <= rsq;
   assign on_grid = px >= 0 && px < fsg_pkg::GridWidth && py >= 0 && py < fsg_pkg::GridHeight;
   assign dsel = (state_ff == S_TD1) ? lfsr_adv[0] : dir_ff;
   assign xa = (XW+2)'(tx_ff) + (dsel ? (XW+2)'(1) : -(XW+2)'(1));
   assign xb = (XW+2)'(tx_ff) - (dsel ? (XW+2)'(1) : -(XW+2)'(1));
   assign xa_ok = xa >= 0 && xa < fsg_pkg::GridWidth;
   assign xb_ok = xb >= 0 && xb < fsg_pkg::GridWidth;
   assign ty_dn = ty_ff + YW'(1);
   assign var_sat = (cur_ff[7:2] > 6'd50) ? 6'd50 : cur_ff[7:2];

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; lfsr_in = lfsr_ff; req_in = req_ff;
      rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff; i_in = i_ff; j_in = j_ff;
      rad_in = rad_ff; tx_in = tx_ff; ty_in = ty_ff; cur_in = cur_ff; dir_in = dir_ff;
      wr_en = 1'b0; wr_addr = {ty_ff, tx_ff}; wr_data = '0; rd_addr = {ty_ff, tx_ff};
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1; wr_addr = clr_ff[AW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(fsg_pkg::CellCount - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               unique case (req_data.opcode)
                  fsg_pkg::OP_PAINT: begin
                     rad_in = (req_data.brush_radius > 3'(fsg_pkg::MaxRadius)) ?
                              RW'(fsg_pkg::MaxRadius) : RW'(req_data.brush_radius);
                     i_in = -signed'(rad_in); j_in = -signed'(rad_in);
                     state_in = (req_data.brush_mode > fsg_pkg::KIND_STONE) ? S_OUT : S_PRD;
                  end
                  fsg_pkg::OP_TICK: begin
                     tx_in = '0; ty_in = YW'(fsg_pkg::GridHeight - 2);
                     state_in = S_TRD;
                  end
                  fsg_pkg::OP_READ: begin
                     tx_in = XW'(req_data.pos_x); ty_in = YW'(req_data.pos_y);
                     state_in = S_RRD;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_PRD: begin
            tx_in = px[XW-1:0]; ty_in = py[YW-1:0];
            state_in = (in_disk && on_grid) ? S_PCHK : S_PNXT;
         end
         S_PCHK: begin
            if (req_ff.brush_mode == fsg_pkg::MODE_ERASE) begin
               wr_en = 1'b1; wr_addr = {ty_ff, tx_ff}; wr_data = '0;
               state_in = S_PNXT;
            end else begin
               state_in = S_RWAIT;
            end
         end
         S_RWAIT: begin
            if (req_ff.opcode == fsg_pkg::OP_READ) begin
               cur_in = rd_data;
               state_in = S_OUT;
            end else begin
               if (rd_data[1:0] == fsg_pkg::KIND_EMPTY) begin
                  lfsr_in = lfsr_adv;
                  wr_en = 1'b1; wr_addr = {ty_ff, tx_ff};
                  wr_data = (req_ff.brush_mode == fsg_pkg::KIND_SAND) ?
                            {var_prod[21:16], fsg_pkg::KIND_SAND} : {6'd0, fsg_pkg::KIND_STONE};
               end
               state_in = S_PNXT;
            end
         end
         S_PNXT: begin
            if (j_ff == signed'(rad_ff)) begin
               j_in = -signed'(rad_ff);
               if (i_ff == signed'(rad_ff)) state_in = S_OUT;
               else begin i_in = i_ff + RW'(1); state_in = S_PRD; end
            end else begin
               j_in = j_ff + RW'(1); state_in = S_PRD;
            end
         end
         S_RRD: begin
            cur_in = '0;
            if ({1'b0, req_ff.pos_x} < (XW+1)'(fsg_pkg::GridWidth) &&
                {1'b0, req_ff.pos_y} < (YW+1)'(fsg_pkg::GridHeight))
               state_in = S_RWAIT;
            else state_in = S_OUT;
         end
         S_TRD: begin
            state_in = S_TBEL;
         end
         S_TBEL: begin
            cur_in = rd_data;
            rd_addr = {ty_dn, tx_ff};
            state_in = (rd_data[1:0] == fsg_pkg::KIND_SAND) ? S_TD1 : S_TNXT;
         end
         S_TD1: begin
            if (rd_data[1:0] == fsg_pkg::KIND_EMPTY) begin
               wr_en = 1'b1; wr_addr = {ty_dn, tx_ff}; wr_data = cur_ff;
               state_in = S_TCLR;
            end else begin
               dir_in = lfsr_adv[0]; lfsr_in = lfsr_adv;
               rd_addr = {ty_dn, xa[XW-1:0]};
               state_in = S_TD2;
            end
         end
         S_TD2: begin
            if (xa_ok && rd_data[1:0] == fsg_pkg::KIND_EMPTY) begin
               wr_en = 1'b1; wr_addr = {ty_dn, xa[XW-1:0]}; wr_data = cur_ff;
               state_in = S_TCLR;
            end else begin
               rd_addr = {ty_dn, xb[XW-1:0]};
               state_in = S_TD3;
            end
         end
         S_TD3: begin
            if (xb_ok && rd_data[1:0] == fsg_pkg::KIND_EMPTY) begin
               wr_en = 1'b1; wr_addr = {ty_dn, xb[XW-1:0]}; wr_data = cur_ff;
               state_in = S_TCLR;
            end else begin
               state_in = S_TNXT;
            end
         end
         S_TCLR: begin
            wr_en = 1'b1; wr_addr = {ty_ff, tx_ff}; wr_data = '0;
            state_in = S_TNXT;
         end
         S_TNXT: begin
            if (tx_ff == XW'(fsg_pkg::GridWidth - 1)) begin
               tx_in = '0;
               if (ty_ff == '0) state_in = S_OUT;
               else begin ty_in = ty_ff - YW'(1); state_in = S_TBEL; end
            end else begin
               tx_in = tx_ff + XW'(1); state_in = S_TBEL;
            end
            rd_addr = {ty_in, tx_in};
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (req_ff.opcode == fsg_pkg::OP_READ) begin
                  unique case (cur_ff[1:0])
                     fsg_pkg::KIND_SAND:
                        rsp_in = {fsg_pkg::KIND_SAND, 8'd255 - 8'(var_sat),
                                  8'd200 - 8'(var_sat), 8'd50};
                     fsg_pkg::KIND_STONE:
                        rsp_in = {fsg_pkg::KIND_STONE, 8'd130, 8'd130, 8'd130};
                     default: rsp_in = '0;
                  endcase
               end else begin
                  rsp_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_wr_en) begin
         lfsr_in = (csr_wr_data == 16'd0) ? 16'd1 : csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; lfsr_ff <= 16'd1; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; lfsr_ff <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in; rsp_ff <= rsp_in; i_ff <= i_in; j_ff <= j_in; rad_ff <= rad_in;
      tx_ff <= tx_in; ty_ff <= ty_in; cur_ff <= cur_in; dir_ff <= dir_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic req_take, rsp_wait;
   assign req_take = req_valid && !req_stall;
   assign rsp_wait = rsp_valid && rsp_stall;

`include "falling_sand_grid_step_top_assert.svh"
   `FSG_ASSERT_IMPL(a_idle_accept, clock, reset, req_take, state_ff == S_IDLE, "busy accept")
   `FSG_ASSERT_NEXT(a_lfsr_nz, clock, reset, 1'b1, lfsr_ff != 16'd0, "lfsr reached zero")
   `FSG_ASSERT_IMPL(a_clear_stall, clock, reset, state_ff == S_CLEAR, req_stall, "clear accept")
   `FSG_ASSERT_NEXT(a_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_ff), "result moved")
endmodule
